>>> hdl/lsrs_pkg.sv
// ----------------------------------------------------------------------------
// lsrs_pkg
// Shared types, codes and helpers for the link session reconnect supervisor.
// ----------------------------------------------------------------------------
package lsrs_pkg;

	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int STEP_W    = 24;
	localparam int TIME_W    = 32;
	localparam int IDX_W     = 3;
	localparam int STATUS_W  = 3;
	localparam int LADDER_N  = 5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_LINK_DOWN       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LINK_CONNECTING = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LINK_UP         = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SESSION_UP      = 3'd4;

	// register indexes (byte address bits [4:2])
	localparam logic [2:0] REG_STEP0         = 3'd0;
	localparam logic [2:0] REG_STEP1         = 3'd1;
	localparam logic [2:0] REG_STEP2         = 3'd2;
	localparam logic [2:0] REG_STEP3         = 3'd3;
	localparam logic [2:0] REG_STEP4         = 3'd4;
	localparam logic [2:0] REG_ASSOC_TIMEOUT = 3'd5;

	localparam logic [IDX_W-1:0] LADDER_LAST = 3'd4;

	localparam logic [STEP_W-1:0] STEP0_RST         = 24'd1000;
	localparam logic [STEP_W-1:0] STEP1_RST         = 24'd2000;
	localparam logic [STEP_W-1:0] STEP2_RST         = 24'd5000;
	localparam logic [STEP_W-1:0] STEP3_RST         = 24'd10000;
	localparam logic [STEP_W-1:0] STEP4_RST         = 24'd30000;
	localparam logic [STEP_W-1:0] ASSOC_TIMEOUT_RST = 24'd15000;

	typedef struct packed {
		logic [LADDER_N-1:0][STEP_W-1:0] step;
		logic [STEP_W-1:0]               assoc_timeout;
	} lsrs_cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TIME_W-1:0]   retry_deadline;
		logic [TIME_W-1:0]   assoc_start;
		logic [IDX_W-1:0]    link_idx;
		logic [IDX_W-1:0]    sess_idx;
		logic                services_started;
	} lsrs_state_t;

	typedef struct packed {
		logic begin_association;
		logic drop_association;
		logic close_socket;
		logic attempt_session;
		logic session_established;
		logic start_services;
	} lsrs_pulse_t;

	localparam lsrs_state_t STATE_RST = '{
		status:           ST_LINK_DOWN,
		retry_deadline:   '0,
		assoc_start:      '0,
		link_idx:         '0,
		sess_idx:         '0,
		services_started: 1'b0
	};

	// delay at a ladder index; anything past the last step reads the last step
	function automatic logic [STEP_W-1:0] ladder_pick(lsrs_cfg_t c, logic [IDX_W-1:0] i);
		logic [STEP_W-1:0] d;
		case (i)
			3'd0:    d = c.step[0];
			3'd1:    d = c.step[1];
			3'd2:    d = c.step[2];
			3'd3:    d = c.step[3];
			default: d = c.step[4];
		endcase
		return d;
	endfunction

	// raise an index by one, saturating at the last step
	function automatic logic [IDX_W-1:0] ladder_next(logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] n;
		if (i >= LADDER_LAST) begin
			n = LADDER_LAST;
		end else begin
			n = i + 3'd1;
		end
		return n;
	endfunction

endpackage

>>> hdl/lsrs_ifs.sv
// ----------------------------------------------------------------------------
// lsrs_ifs
// Valid/ready channels for tick requests and status results.
// ----------------------------------------------------------------------------
interface lsrs_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        associated;
	logic        session_alive;
	logic        connect_ok;

	modport source (output valid, now_ms, associated, session_alive, connect_ok,
		input ready);
	modport sink (input valid, now_ms, associated, session_alive, connect_ok,
		output ready);
endinterface

interface lsrs_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       begin_association;
	logic       drop_association;
	logic       close_socket;
	logic       attempt_session;
	logic       session_established;
	logic       start_services;

	modport source (output valid, status, begin_association, drop_association,
		close_socket, attempt_session, session_established, start_services,
		input ready);
	modport sink (input valid, status, begin_association, drop_association,
		close_socket, attempt_session, session_established, start_services,
		output ready);
endinterface

>>> hdl/lsrs_cfg.sv
// ----------------------------------------------------------------------------
// lsrs_cfg
// APB register file: five backoff ladder steps and the association timeout.
// ----------------------------------------------------------------------------
module lsrs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsrs_pkg::APB_AW-1:0] paddr,
	input  logic [lsrs_pkg::APB_DW-1:0] pwdata,
	output logic [lsrs_pkg::APB_DW-1:0] prdata,
	output lsrs_pkg::lsrs_cfg_t         cfg
);
	import lsrs_pkg::*;

	lsrs_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step[0]       <= STEP0_RST;
			cfg_q.step[1]       <= STEP1_RST;
			cfg_q.step[2]       <= STEP2_RST;
			cfg_q.step[3]       <= STEP3_RST;
			cfg_q.step[4]       <= STEP4_RST;
			cfg_q.assoc_timeout <= ASSOC_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STEP0:         cfg_q.step[0]       <= pwdata[STEP_W-1:0];
				REG_STEP1:         cfg_q.step[1]       <= pwdata[STEP_W-1:0];
				REG_STEP2:         cfg_q.step[2]       <= pwdata[STEP_W-1:0];
				REG_STEP3:         cfg_q.step[3]       <= pwdata[STEP_W-1:0];
				REG_STEP4:         cfg_q.step[4]       <= pwdata[STEP_W-1:0];
				REG_ASSOC_TIMEOUT: cfg_q.assoc_timeout <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEP0:         prdata = {8'd0, cfg_q.step[0]};
			REG_STEP1:         prdata = {8'd0, cfg_q.step[1]};
			REG_STEP2:         prdata = {8'd0, cfg_q.step[2]};
			REG_STEP3:         prdata = {8'd0, cfg_q.step[3]};
			REG_STEP4:         prdata = {8'd0, cfg_q.step[4]};
			REG_ASSOC_TIMEOUT: prdata = {8'd0, cfg_q.assoc_timeout};
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/lsrs_step.sv
// ----------------------------------------------------------------------------
// lsrs_step
// Next-state and pulse logic for one tick of the reconnect supervisor.
// ----------------------------------------------------------------------------
module lsrs_step (
	input  lsrs_pkg::lsrs_cfg_t   cfg,
	input  lsrs_pkg::lsrs_state_t cur,
	input  logic [31:0]           now_ms,
	input  logic                  associated,
	input  logic                  session_alive,
	input  logic                  connect_ok,
	output lsrs_pkg::lsrs_state_t nxt,
	output lsrs_pkg::lsrs_pulse_t pulse
);
	import lsrs_pkg::*;

	logic                lost;
	logic [STATUS_W-1:0] st_a;
	logic [TIME_W-1:0]   dl_a;
	logic [IDX_W-1:0]    lidx_a;
	logic [TIME_W-1:0]   since_dl;
	logic                due;
	logic [TIME_W-1:0]   elapsed;
	logic                timed_out;
	logic [IDX_W-1:0]    ladder_idx;
	logic [STEP_W-1:0]   delay;
	logic [TIME_W-1:0]   fail_deadline;

	// link loss drops to link down first, with the deadline set to now
	assign lost   = !associated && cur.status != ST_LINK_DOWN
		&& cur.status != ST_LINK_CONNECTING;
	assign st_a   = lost ? ST_LINK_DOWN : cur.status;
	assign dl_a   = lost ? now_ms : cur.retry_deadline;
	assign lidx_a = lost ? '0 : cur.link_idx;

	assign since_dl  = now_ms - dl_a;
	assign due       = !since_dl[TIME_W-1];
	assign elapsed   = now_ms - cur.assoc_start;
	assign timed_out = elapsed >= {8'd0, cfg.assoc_timeout};

	// one ladder lookup: link ladder while connecting, session ladder otherwise
	assign ladder_idx    = (st_a == ST_LINK_CONNECTING) ? lidx_a : cur.sess_idx;
	assign delay         = ladder_pick(cfg, ladder_idx);
	assign fail_deadline = now_ms + {8'd0, delay};

	always_comb begin
		nxt                = cur;
		nxt.status         = st_a;
		nxt.retry_deadline = dl_a;
		nxt.link_idx       = lidx_a;
		pulse              = '0;
		pulse.close_socket = lost;
		case (st_a)
			ST_LINK_DOWN: begin
				if (due) begin
					pulse.begin_association = 1'b1;
					nxt.assoc_start         = now_ms;
					nxt.status              = ST_LINK_CONNECTING;
				end
			end
			ST_LINK_CONNECTING: begin
				if (associated) begin
					nxt.link_idx         = '0;
					nxt.status           = ST_LINK_UP;
					nxt.services_started = 1'b1;
					pulse.start_services = !cur.services_started;
					nxt.sess_idx         = '0;
					nxt.retry_deadline   = now_ms;
				end else if (timed_out) begin
					pulse.drop_association = 1'b1;
					nxt.link_idx           = ladder_next(ladder_idx);
					nxt.retry_deadline     = fail_deadline;
					nxt.status             = ST_LINK_DOWN;
				end
			end
			ST_LINK_UP: begin
				if (due) begin
					pulse.attempt_session = 1'b1;
					if (connect_ok) begin
						nxt.sess_idx              = '0;
						nxt.status                = ST_SESSION_UP;
						pulse.session_established = 1'b1;
					end else begin
						nxt.sess_idx       = ladder_next(ladder_idx);
						nxt.retry_deadline = fail_deadline;
					end
				end
			end
			ST_SESSION_UP: begin
				if (!session_alive) begin
					nxt.sess_idx       = ladder_next(ladder_idx);
					nxt.retry_deadline = fail_deadline;
					nxt.status         = ST_LINK_UP;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/link_session_reconnect_supervisor.sv
// ----------------------------------------------------------------------------
// link_session_reconnect_supervisor
// Link and session reconnect supervisor with a five-step backoff ladder.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          carries
//  --------  ---  -----------------  ------------------------------------------
//  tick      in   valid/ready        now_ms, associated, session_alive,
//                                    connect_ok
//  result    out  valid/ready        status and six one-tick command pulses
//  apb       in   psel/penable       ladder steps 0..4 (0x00..0x10),
//                                    assoc_timeout (0x14)
//
//  One tick request enters per cycle unless a stalled result keeps the
//  input register full. It is captured in the input register, stepped
//  against the supervisor state by lsrs_step, and its result lands in the
//  output register, whose valid drives result valid.
//  The state feedback loop (status, deadline, ladder indexes) closes through
//  lsrs_step into the state register and never holds a tick back.
//  arst_n clears both stage valids and returns the state and the config
//  registers to their reset values; no sweep is needed.
//  A stalled result holds the output register; the input register still
//  drains into it the cycle the result is taken, so no bubble is added.
//
module link_session_reconnect_supervisor (
	input  logic                        clk,
	input  logic                        arst_n,
	lsrs_tick_if.sink                   tick,
	lsrs_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsrs_pkg::APB_AW-1:0] paddr,
	input  logic [lsrs_pkg::APB_DW-1:0] pwdata,
	output logic [lsrs_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import lsrs_pkg::*;

	lsrs_cfg_t   cfg;

	// input register
	logic        v_s1;
	logic [31:0] now_ms_s1;
	logic        associated_s1;
	logic        session_alive_s1;
	logic        connect_ok_s1;

	// supervisor state
	lsrs_state_t state_q;
	lsrs_state_t state_nxt;
	lsrs_pulse_t pulse_nxt;

	// output register
	logic                v_s2;
	logic [STATUS_W-1:0] status_s2;
	lsrs_pulse_t         pulse_s2;

	logic take;
	logic adv;

	assign pready = 1'b1;

	lsrs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lsrs_step u_step (
		.cfg           (cfg),
		.cur           (state_q),
		.now_ms        (now_ms_s1),
		.associated    (associated_s1),
		.session_alive (session_alive_s1),
		.connect_ok    (connect_ok_s1),
		.nxt           (state_nxt),
		.pulse         (pulse_nxt)
	);

	// advance the captured tick whenever the output register is free or
	// being emptied this cycle; accept a new tick whenever the input
	// register is free or advancing
	assign adv        = v_s1 && (!v_s2 || result.ready);
	assign tick.ready = !v_s1 || adv;
	assign take       = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			state_q <= STATE_RST;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2    <= 1'b1;
				state_q <= state_nxt;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// payload: hold unless loaded
	always_ff @(posedge clk) begin
		if (take) begin
			now_ms_s1        <= tick.now_ms;
			associated_s1    <= tick.associated;
			session_alive_s1 <= tick.session_alive;
			connect_ok_s1    <= tick.connect_ok;
		end
		if (adv) begin
			status_s2 <= state_nxt.status;
			pulse_s2  <= pulse_nxt;
		end
	end

	assign result.valid               = v_s2;
	assign result.status              = status_s2;
	assign result.begin_association   = pulse_s2.begin_association;
	assign result.drop_association    = pulse_s2.drop_association;
	assign result.close_socket        = pulse_s2.close_socket;
	assign result.attempt_session     = pulse_s2.attempt_session;
	assign result.session_established = pulse_s2.session_established;
	assign result.start_services      = pulse_s2.start_services;

	// a link loss always restarts association in the same tick
	a_close_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && pulse_s2.close_socket |->
			pulse_s2.begin_association && status_s2 == ST_LINK_CONNECTING)
		else $error("close_socket without a new association");

	// an established session comes from an attempt and lands in session up
	a_est_attempt: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && pulse_s2.session_established |->
			pulse_s2.attempt_session && status_s2 == ST_SESSION_UP)
		else $error("session_established without attempt or session up");

	a_begin_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !(pulse_s2.begin_association && pulse_s2.drop_association))
		else $error("begin and drop association in one tick");

	// services start only on a link-up, and the flag is set from then on
	a_services: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pulse_nxt.start_services |=>
			state_q.services_started && status_s2 == ST_LINK_UP)
		else $error("start_services without link up");

	// the result register shows the status the state just took
	a_status_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> status_s2 == state_q.status)
		else $error("result status differs from stored status");

endmodule

>>> dv/lsrs_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsrs_status_checker
// Tracks supervisor state from accepted tick requests and register writes,
// predicts the status and command pulses and checks each accepted result.
// ----------------------------------------------------------------------------
module lsrs_status_checker
	import lsrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	lsrs_tick_if              tick,
	lsrs_result_if            result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                fail_total,
	output int                outstanding
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		lsrs_pulse_t         pulse;
	} tick_outcome_t;

	logic [STEP_W-1:0] ladder [LADDER_N];
	logic [STEP_W-1:0] assoc_limit;
	lsrs_state_t       sup;
	tick_outcome_t     outcome_q [$];
	int                fails = 0;

	function automatic logic is_due(logic [TIME_W-1:0] now, logic [TIME_W-1:0] deadline);
		logic [TIME_W-1:0] diff;
		diff = now - deadline;
		return !diff[TIME_W-1];
	endfunction

	function automatic logic [TIME_W-1:0] backoff_delay(logic [IDX_W-1:0] idx);
		logic [TIME_W-1:0] d;
		d = ladder[(idx > LADDER_LAST) ? LADDER_LAST : idx];
		return d;
	endfunction

	function automatic logic [IDX_W-1:0] ladder_step_up(logic [IDX_W-1:0] idx);
		return (idx >= LADDER_LAST) ? LADDER_LAST : idx + 1'b1;
	endfunction

	// one tick of the supervisor against the shadow state
	task automatic advance_supervisor(input logic [TIME_W-1:0] now, input logic assoc,
		input logic alive, input logic conn_ok, output tick_outcome_t res);
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] limit;
		res = '0;
		limit = assoc_limit;
		// link loss drops to link down first; the down branch below then sees it
		if (!assoc && sup.status != ST_LINK_DOWN && sup.status != ST_LINK_CONNECTING) begin
			res.pulse.close_socket = 1'b1;
			sup.link_idx = '0;
			sup.retry_deadline = now;
			sup.status = ST_LINK_DOWN;
		end
		elapsed = now - sup.assoc_start;
		case (sup.status)
			ST_LINK_DOWN: begin
				if (is_due(now, sup.retry_deadline)) begin
					res.pulse.begin_association = 1'b1;
					sup.assoc_start = now;
					sup.status = ST_LINK_CONNECTING;
				end
			end
			ST_LINK_CONNECTING: begin
				if (assoc) begin
					sup.link_idx = '0;
					sup.status = ST_LINK_UP;
					if (!sup.services_started) begin
						sup.services_started = 1'b1;
						res.pulse.start_services = 1'b1;
					end
					sup.sess_idx = '0;
					sup.retry_deadline = now;
				end else if (elapsed >= limit) begin
					res.pulse.drop_association = 1'b1;
					sup.retry_deadline = now + backoff_delay(sup.link_idx);
					sup.link_idx = ladder_step_up(sup.link_idx);
					sup.status = ST_LINK_DOWN;
				end
			end
			ST_LINK_UP: begin
				if (is_due(now, sup.retry_deadline)) begin
					res.pulse.attempt_session = 1'b1;
					if (conn_ok) begin
						sup.sess_idx = '0;
						sup.status = ST_SESSION_UP;
						res.pulse.session_established = 1'b1;
					end else begin
						sup.retry_deadline = now + backoff_delay(sup.sess_idx);
						sup.sess_idx = ladder_step_up(sup.sess_idx);
					end
				end
			end
			ST_SESSION_UP: begin
				if (!alive) begin
					sup.retry_deadline = now + backoff_delay(sup.sess_idx);
					sup.sess_idx = ladder_step_up(sup.sess_idx);
					sup.status = ST_LINK_UP;
				end
			end
			default: begin
			end
		endcase
		res.status = sup.status;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			fails++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tick_outcome_t fresh;
		tick_outcome_t oldest;
		if (!arst_n) begin
			ladder[0] = STEP0_RST;
			ladder[1] = STEP1_RST;
			ladder[2] = STEP2_RST;
			ladder[3] = STEP3_RST;
			ladder[4] = STEP4_RST;
			assoc_limit = ASSOC_TIMEOUT_RST;
			sup = STATE_RST;
			outcome_q.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_STEP0, REG_STEP1, REG_STEP2, REG_STEP3, REG_STEP4: begin
						ladder[paddr[APB_AW-1:2]] = pwdata[STEP_W-1:0];
					end
					REG_ASSOC_TIMEOUT: begin
						assoc_limit = pwdata[STEP_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (tick.valid && tick.ready) begin
				advance_supervisor(tick.now_ms, tick.associated, tick.session_alive,
					tick.connect_ok, fresh);
				outcome_q.push_back(fresh);
			end
			if (result.valid && result.ready) begin
				if (outcome_q.size() == 0) begin
					fails++;
					$error("result: none expected, actual status %0d", result.status);
				end else begin
					oldest = outcome_q.pop_front();
					check_field("status", oldest.status, result.status);
					check_field("begin_association", oldest.pulse.begin_association,
						result.begin_association);
					check_field("drop_association", oldest.pulse.drop_association,
						result.drop_association);
					check_field("close_socket", oldest.pulse.close_socket, result.close_socket);
					check_field("attempt_session", oldest.pulse.attempt_session,
						result.attempt_session);
					check_field("session_established", oldest.pulse.session_established,
						result.session_established);
					check_field("start_services", oldest.pulse.start_services,
						result.start_services);
				end
			end
			outstanding <= outcome_q.size();
			fail_total <= fails;
		end
	end

endmodule

>>> dv/tb_link_session_reconnect_supervisor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_link_session_reconnect_supervisor
// Drives tick requests and register writes into the reconnect supervisor and
// gives the verdict. A side checker predicts every result and compares it;
// stimulus is a directed walk through the ladder and the wrap-safe deadline
// cases, then random link/session histories under several ladder settings.
// ----------------------------------------------------------------------------
module tb_link_session_reconnect_supervisor;
	import lsrs_pkg::*;

	// settle time after each drain, before reprogramming and before the verdict
	localparam int          SETTLE_CYCLES = 4;
	localparam int unsigned CYCLE_LIMIT   = 500000;

	// register slots past the last defined one; writes there must be dropped
	localparam logic [2:0] REG_HOLE_A = 3'd6;
	localparam logic [2:0] REG_HOLE_B = 3'd7;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              associated;
		logic              session_alive;
		logic              connect_ok;
	} tick_req_t;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_CYCLIC} sink_mode_e;
	typedef enum int {PH_ZERO, PH_MAX, PH_SHORT, PH_WIDE, PH_DEFAULT} cfg_phase_e;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int          failures;
	int          open_results;
	int unsigned cycle_count = 0;
	int          burst_left  = 0;
	tick_req_t   link_env;

	lsrs_tick_if   tick_ch ();
	lsrs_result_if result_ch ();

	link_session_reconnect_supervisor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lsrs_status_checker status_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick_ch),
		.result      (result_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_total  (failures),
		.outstanding (open_results)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Hard stop: nothing correct takes anywhere near this long.
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("[link_session_reconnect_supervisor] ERROR");
		$finish;
	end

	// Result side: switch between stall patterns after random spans so that
	// stalls land on every pipeline phase, with open stretches in between.
	initial begin
		sink_mode_e mode;
		int         span;
		int         phase;
		mode  = SINK_OPEN;
		span  = 0;
		phase = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = sink_mode_e'($urandom_range(0, 3));
				span = $urandom_range(16, 160);
			end
			span--;
			phase++;
			case (mode)
				SINK_OPEN:   result_ch.ready <= 1'b1;
				SINK_COIN:   result_ch.ready <= ($urandom_range(0, 1) == 1);
				SINK_SPARSE: result_ch.ready <= ($urandom_range(0, 7) == 0);
				default:     result_ch.ready <= ((phase % 5) < 2);
			endcase
		end
	end

	// Step for the simulated clock: mostly forward in ladder-sized strides,
	// sometimes standing still, sometimes a wild jump or a step backward.
	function automatic logic [TIME_W-1:0] time_advance();
		int unsigned       pick;
		logic [TIME_W-1:0] delta;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			delta = '0;
		end else if (pick < 45) begin
			delta = $urandom_range(1, 600);
		end else if (pick < 75) begin
			delta = $urandom_range(600, 6000);
		end else if (pick < 92) begin
			delta = $urandom_range(6000, 40000);
		end else if (pick < 96) begin
			delta = $urandom;
		end else begin
			delta = 32'd0 - $urandom_range(1, 3000);
		end
		return delta;
	endfunction

	// Next random request. Most follow a plausible link history: time moves on,
	// association and session flags come and go in runs. A few flap the link
	// every tick, and a few are pure noise that leaves the history alone.
	function automatic tick_req_t next_request();
		tick_req_t   r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			r.now_ms        = $urandom;
			r.associated    = $urandom_range(0, 1);
			r.session_alive = $urandom_range(0, 1);
			r.connect_ok    = $urandom_range(0, 1);
		end else begin
			link_env.now_ms = link_env.now_ms + time_advance();
			if (link_env.associated) begin
				link_env.associated = ($urandom_range(0, 39) != 0);
			end else begin
				link_env.associated = ($urandom_range(0, 3) == 0);
			end
			if (pick < 12) begin
				link_env.associated = !link_env.associated;
			end
			if (link_env.session_alive) begin
				link_env.session_alive = ($urandom_range(0, 14) != 0);
			end else begin
				link_env.session_alive = ($urandom_range(0, 2) == 0);
			end
			link_env.connect_ok = ($urandom_range(0, 9) < 6);
			r = link_env;
		end
		return r;
	endfunction

	// Drop valid and hold until every predicted result has been taken.
	task automatic drain_results();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
	endtask

	// Offer one tick request and hold it until accepted. Requests go out in
	// bursts; between bursts insert a random gap, or now and then a full drain.
	task automatic offer_request(input tick_req_t r);
		int gap;
		if ($urandom_range(0, 299) == 0) begin
			drain_results();
		end else if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				tick_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		tick_ch.valid         <= 1'b1;
		tick_ch.now_ms        <= r.now_ms;
		tick_ch.associated    <= r.associated;
		tick_ch.session_alive <= r.session_alive;
		tick_ch.connect_ok    <= r.connect_ok;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
	endtask

	// Setup phase, access phase, then psel drops for an idle phase so
	// back-to-back writes never touch psel twice in one step.
	task automatic apb_write(input logic [2:0] reg_idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Load the whole ladder and the association limit for one phase. Upper
	// data bits carry junk where it matters, to show they are dropped.
	task automatic program_phase(input cfg_phase_e ph);
		logic [APB_DW-1:0] val;
		logic [2:0]        reg_idx;
		logic [STEP_W-1:0] reset_vals [LADDER_N+1];
		reset_vals = '{STEP0_RST, STEP1_RST, STEP2_RST, STEP3_RST, STEP4_RST,
			ASSOC_TIMEOUT_RST};
		for (int i = 0; i <= LADDER_N; i++) begin
			reg_idx = (i == LADDER_N) ? REG_ASSOC_TIMEOUT : REG_STEP0 + i[2:0];
			case (ph)
				PH_ZERO: begin
					val = $urandom & 32'hFF00_0000;
				end
				PH_MAX: begin
					val = '1;
				end
				PH_SHORT: begin
					val = (i == LADDER_N) ? $urandom_range(0, 8000) : $urandom_range(0, 3000);
					val[31:24] = $urandom_range(0, 255);
				end
				PH_WIDE: begin
					val = (i == LADDER_N) ? $urandom_range(1000, 40000) : $urandom_range(0, 60000);
				end
				default: begin
					val = reset_vals[i];
				end
			endcase
			apb_write(reg_idx, val);
		end
		apb_write(REG_HOLE_A, $urandom);
		apb_write(REG_HOLE_B, $urandom);
	endtask

	initial begin
		tick_req_t  dir_q [$];
		cfg_phase_e plan [5];
		int         plan_items [5];
		plan       = '{PH_ZERO, PH_MAX, PH_SHORT, PH_WIDE, PH_DEFAULT};
		plan_items = '{200, 200, 500, 500, 200};

		// known values on every input from time zero; reset held low
		arst_n = 1'b0;
		tick_ch.valid         <= 1'b0;
		tick_ch.now_ms        <= '0;
		tick_ch.associated    <= 1'b0;
		tick_ch.session_alive <= 1'b0;
		tick_ch.connect_ok    <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;

		// Directed walk under reset values (ladder 1000/2000/5000/10000/30000,
		// association limit 15000). Fields: now_ms, associated, alive, connect_ok.
		// first tick: deadline zero is due, association begins
		dir_q.push_back('{32'd0,     1'b0, 1'b1, 1'b1});
		dir_q.push_back('{32'd100,   1'b0, 1'b0, 1'b1});
		// association gives up exactly at the limit, retry lands one step later
		dir_q.push_back('{32'd15000, 1'b0, 1'b1, 1'b0});
		dir_q.push_back('{32'd15999, 1'b0, 1'b1, 1'b0});
		dir_q.push_back('{32'd16000, 1'b0, 1'b1, 1'b0});
		// first link up since reset starts services
		dir_q.push_back('{32'd16001, 1'b1, 1'b0, 1'b0});
		// failed session connects climb the ladder and saturate on the last step
		dir_q.push_back('{32'd16001, 1'b1, 1'b1, 1'b0});
		dir_q.push_back('{32'd17001, 1'b1, 1'b1, 1'b0});
		dir_q.push_back('{32'd19001, 1'b1, 1'b1, 1'b0});
		dir_q.push_back('{32'd24001, 1'b1, 1'b1, 1'b0});
		dir_q.push_back('{32'd34001, 1'b1, 1'b1, 1'b0});
		dir_q.push_back('{32'd64001, 1'b1, 1'b1, 1'b0});
		dir_q.push_back('{32'd94001, 1'b1, 1'b1, 1'b1});
		dir_q.push_back('{32'd94002, 1'b1, 1'b1, 1'b0});
		// session dies, falls back to link up with a fresh ladder, then recovers
		dir_q.push_back('{32'd94003, 1'b1, 1'b0, 1'b1});
		dir_q.push_back('{32'd95003, 1'b1, 1'b1, 1'b1});
		// link loss from session up: close and re-associate in the same tick
		dir_q.push_back('{32'd95004, 1'b0, 1'b1, 1'b0});
		// link back, no second services pulse
		dir_q.push_back('{32'd95005, 1'b1, 1'b1, 1'b0});
		// deadline exactly half the clock range ahead reads as not due
		dir_q.push_back('{32'h8001_731D, 1'b1, 1'b1, 1'b1});
		dir_q.push_back('{32'h8001_731C, 1'b1, 1'b1, 1'b0});
		// retry deadline wraps past the top of the clock
		dir_q.push_back('{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0});
		dir_q.push_back('{32'h0000_0000, 1'b1, 1'b1, 1'b1});
		dir_q.push_back('{32'h0000_07CF, 1'b1, 1'b1, 1'b1});
		dir_q.push_back('{32'h0000_07D0, 1'b0, 1'b0, 1'b1});
		dir_q.push_back('{32'h0000_07D0, 1'b0, 1'b0, 1'b0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_q[i]) begin
			offer_request(dir_q[i]);
		end
		link_env = dir_q[dir_q.size() - 1];

		// Each phase: wait out the pipeline, reprogram, then run random histories.
		foreach (plan[p]) begin
			drain_results();
			repeat (SETTLE_CYCLES) @(posedge clk);
			program_phase(plan[p]);
			repeat (plan_items[p]) begin
				offer_request(next_request());
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (failures == 0 && open_results == 0) begin
			$display("[link_session_reconnect_supervisor] OK");
		end else begin
			$display("[link_session_reconnect_supervisor] ERROR");
		end
		$finish;
	end

endmodule
